>>> rtl/core/tdh_pkg.sv
// Shared types and codes for the two-dimensional histogram tally unit.
`default_nettype none

package tdh_pkg;

    localparam logic OP_TALLY = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd0;
    localparam logic [1:0] STATUS_DONE         = 2'd1;
    localparam logic [1:0] STATUS_MULTI_HIT    = 2'd2;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] energy_idx;
        logic signed [15:0] psd_bin;
        logic [2:0]         detector_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] bin_count;
        logic [31:0] multi_hit_count;
    } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/tdh_bin_ram.sv
// Single-port-write, single-port-read bin memory with registered read data.
`default_nettype none

module tdh_bin_ram #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [15:0]       wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [15:0]       rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/two_d_histogram_tally_unit.sv
// Top level of the two-dimensional histogram tally unit.
//
// Input channel s_*: one item per transfer, either a tally of an event
// (energy bin, pulse-shape bin, detector id) or a read of one bin.
// Result channel m_*: exactly one result per input item, in order.
// Bins live in one memory of BANKS*X_BINS*Y_BINS 16-bit entries with
// registered read data. An item is accepted and its bin is read; when it
// advances, the bin is incremented (tallies only), written back and the
// result registered, which raises m_valid. Up to one item per cycle is
// taken while m_ready is high: a write in the same cycle as the next read of that bin
// is forwarded from the last-write register. A tally with a multi-hit id bumps a 32-bit
// counter kept in flip-flops instead of a bin.
// After reset the unit sweeps the memory to zero, one entry per cycle,
// over all BANKS*X_BINS*Y_BINS entries (32768 with the defaults);
// s_ready stays low until the sweep ends.
// When m_ready is low while m_valid is high, the result register holds, the item
// behind it holds and s_ready is low while stage one is full; nothing is lost or repeated.
`default_nettype none

module two_d_histogram_tally_unit #(
    parameter int X_BINS = 256,
    parameter int Y_BINS = 32,
    parameter int BANKS  = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tdh_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tdh_pkg::out_item_t     m_item
);

    localparam int BANK_SIZE = X_BINS * Y_BINS;
    localparam int DEPTH     = BANKS * BANK_SIZE;
    localparam int ADDR_W    = $clog2(DEPTH);

    // Decode of the incoming item
    logic              x_ok;
    logic              y_ok;
    logic              id_bank;
    logic              s_bank_hit;
    logic              s_multi;
    logic [ADDR_W-1:0] s_addr;
    logic              s_accept;

    // Stage one: bin read in flight
    logic              p1_valid_reg;
    logic              p1_op_reg;
    logic              p1_bank_hit_reg;
    logic              p1_multi_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    logic              p1_adv;

    // Last write, for forwarding
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [15:0]       fwd_data_reg;

    // Clearing sweep
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic [31:0]       multi_cnt_reg;
    logic [31:0]       multi_cnt_next;
    logic              m_valid_reg;
    tdh_pkg::out_item_t m_item_reg;
    tdh_pkg::out_item_t m_item_next;

    logic [15:0]       rd_data;
    logic [15:0]       old_bin;
    logic [15:0]       new_bin;
    logic              bin_wr;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [15:0]       ram_wr_data;

    assign x_ok    = !s_item.energy_idx[15] && ($unsigned(s_item.energy_idx) < 16'(X_BINS));
    assign y_ok    = !s_item.psd_bin[15] && ($unsigned(s_item.psd_bin) < 16'(Y_BINS));
    assign id_bank = {1'b0, s_item.detector_id} < 4'(BANKS);

    assign s_bank_hit = x_ok && y_ok && id_bank;
    assign s_multi    = x_ok && y_ok && !id_bank && (s_item.operation == tdh_pkg::OP_TALLY);

    always_comb begin
        s_addr = '0;
        if (s_bank_hit) begin
            s_addr = ADDR_W'(s_item.detector_id) * ADDR_W'(BANK_SIZE)
                   + ADDR_W'($unsigned(s_item.energy_idx)) * ADDR_W'(Y_BINS)
                   + ADDR_W'($unsigned(s_item.psd_bin));
        end
    end

    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !clearing_reg && (!p1_valid_reg || p1_adv);
    assign s_accept = s_valid && s_ready;

    // Take the newest written value when the read raced the write
    assign old_bin = (fwd_valid_reg && (fwd_addr_reg == p1_addr_reg)) ? fwd_data_reg : rd_data;
    assign new_bin = (p1_op_reg == tdh_pkg::OP_TALLY) ? old_bin + 16'd1 : old_bin;
    assign bin_wr  = p1_adv && p1_bank_hit_reg && (p1_op_reg == tdh_pkg::OP_TALLY);

    always_comb begin
        multi_cnt_next = multi_cnt_reg;
        m_item_next    = '0;
        if (p1_bank_hit_reg) begin
            m_item_next.status    = tdh_pkg::STATUS_DONE;
            m_item_next.bin_count = new_bin;
        end else if (p1_multi_reg) begin
            multi_cnt_next       = multi_cnt_reg + 32'd1;
            m_item_next.status   = tdh_pkg::STATUS_MULTI_HIT;
        end else begin
            m_item_next.status   = tdh_pkg::STATUS_OUT_OF_RANGE;
        end
        m_item_next.multi_hit_count = multi_cnt_next;
    end

    always_comb begin
        if (clearing_reg) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = bin_wr;
            ram_wr_addr = p1_addr_reg;
            ram_wr_data = new_bin;
        end
    end

    tdh_bin_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_bin_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (s_accept),
        .rd_addr (s_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            multi_cnt_reg <= '0;
        end else begin
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (bin_wr) begin
                fwd_valid_reg <= 1'b1;
            end
            if (p1_adv) begin
                m_valid_reg   <= 1'b1;
                multi_cnt_reg <= multi_cnt_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_op_reg       <= s_item.operation;
            p1_bank_hit_reg <= s_bank_hit;
            p1_multi_reg    <= s_multi;
            p1_addr_reg     <= s_addr;
        end
        if (bin_wr) begin
            fwd_addr_reg <= p1_addr_reg;
            fwd_data_reg <= new_bin;
        end
        if (p1_adv) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the two-dimensional histogram tally unit.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int X_BINS       = 256;
    localparam int Y_BINS       = 32;
    localparam int BANKS        = 4;
    localparam int CLK_PERIOD   = 8;
    localparam int DIR_ROWS     = 25;
    localparam int RANDOM_ITEMS = 1500;
    localparam int RUN_BASE     = DIR_ROWS;
    localparam int HOLD_MARK    = RUN_BASE + 200;
    localparam int HOLD_CYCLES  = 400;
    localparam longint LIMIT_CYCLES = 2_500_000;

    typedef struct {
        tdh_pkg::in_item_t  item;
        bit                 typed;
        tdh_pkg::out_item_t want;
    } stim_row_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    tdh_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    tdh_pkg::out_item_t m_item;

    // Model of the unit: every bin of every bank and the multi-hit counter
    logic [15:0] bin_store [BANKS*X_BINS*Y_BINS];
    logic [31:0] multi_hits = '0;

    stim_row_t          want_plan [$];
    tdh_pkg::out_item_t due_results [$];
    stim_row_t          dir_tab [DIR_ROWS];
    stim_row_t          plan_row;
    tdh_pkg::out_item_t next_want;
    tdh_pkg::out_item_t tallied;
    int          in_taken = 0;
    int          results_seen = 0;
    int          errors = 0;
    logic        steady;

    // Run without idling on either side for a stretch of the random part
    assign steady = (in_taken >= RUN_BASE + 600) && (in_taken < RUN_BASE + 900);

    two_d_histogram_tally_unit #(
        .X_BINS(X_BINS),
        .Y_BINS(Y_BINS),
        .BANKS (BANKS)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD/2) aclk = ~aclk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("two_d_histogram_tally_unit: mismatch");
        $finish;
    end

    function automatic tdh_pkg::out_item_t tally_bin(tdh_pkg::in_item_t it);
        tdh_pkg::out_item_t r;
        int          x;
        int          y;
        int unsigned a;
        x = it.energy_idx;
        y = it.psd_bin;
        r = '0;
        if (x >= 0 && x < X_BINS && y >= 0 && y < Y_BINS) begin
            if (it.detector_id < BANKS) begin
                a = (int'(it.detector_id) * X_BINS + x) * Y_BINS + y;
                if (it.operation == tdh_pkg::OP_TALLY)
                    bin_store[a] = bin_store[a] + 16'd1;
                r.bin_count = bin_store[a];
                r.status    = tdh_pkg::STATUS_DONE;
            end else if (it.operation == tdh_pkg::OP_TALLY) begin
                multi_hits = multi_hits + 32'd1;
                r.status   = tdh_pkg::STATUS_MULTI_HIT;
            end
        end
        r.multi_hit_count = multi_hits;
        return r;
    endfunction

    function automatic stim_row_t dir_row(logic op, int x, int y, int id, bit typed,
                                          logic [1:0] st, int cnt, int mh);
        stim_row_t r;
        r.item.operation        = op;
        r.item.energy_idx       = 16'(x);
        r.item.psd_bin          = 16'(y);
        r.item.detector_id      = 3'(id);
        r.typed                 = typed;
        r.want.status           = st;
        r.want.bin_count        = 16'(cnt);
        r.want.multi_hit_count  = 32'(mh);
        return r;
    endfunction

    function automatic tdh_pkg::in_item_t random_event();
        tdh_pkg::in_item_t it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        it.operation   = ($urandom_range(0, 99) < 70) ? tdh_pkg::OP_TALLY : tdh_pkg::OP_READ;
        it.detector_id = ($urandom_range(0, 99) < 75) ? 3'($urandom_range(0, BANKS-1))
                                                      : 3'($urandom_range(BANKS, 7));
        if (pick < 45) begin
            // a few hot bins, corners included, so counts climb and writes collide
            it.energy_idx = 16'($urandom_range(0, 3) * 85);
            it.psd_bin    = 16'($urandom_range(0, 1) * 31);
        end else if (pick < 85) begin
            it.energy_idx = 16'($urandom_range(0, X_BINS-1));
            it.psd_bin    = 16'($urandom_range(0, Y_BINS-1));
        end else if (pick < 92) begin
            it.energy_idx = $urandom_range(0, 1) ? 16'(X_BINS) : 16'(X_BINS-1);
            it.psd_bin    = $urandom_range(0, 1) ? 16'(-1) : 16'(Y_BINS);
        end else begin
            it.energy_idx = 16'($urandom());
            it.psd_bin    = 16'($urandom());
        end
        return it;
    endfunction

    function automatic void log_fault(string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    task automatic offer(stim_row_t row);
        while (!steady && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        want_plan.push_back(row);
        s_valid <= 1'b1;
        s_item  <= row.item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Predict on every input transfer, check every result transfer
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_taken++;
            plan_row = want_plan.pop_front();
            tallied  = tally_bin(s_item);
            due_results.push_back(plan_row.typed ? plan_row.want : tallied);
        end
        if (m_valid && m_ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
                log_fault($sformatf("unexpected result: status %0d count %0d multi %0d",
                                    m_item.status, m_item.bin_count, m_item.multi_hit_count));
            end else begin
                next_want = due_results.pop_front();
                if (m_item.status !== next_want.status
                        || m_item.bin_count !== next_want.bin_count
                        || m_item.multi_hit_count !== next_want.multi_hit_count)
                    log_fault($sformatf(
                        "result %0d: expected status %0d count %0d multi %0d, got %0d %0d %0d",
                        results_seen, next_want.status, next_want.bin_count,
                        next_want.multi_hit_count, m_item.status, m_item.bin_count,
                        m_item.multi_hit_count));
            end
        end
    end

    // Result side: random back-pressure plus one long hold to fill the pipeline
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && in_taken >= HOLD_MARK) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    initial begin
        stim_row_t row;
        foreach (bin_store[i])
            bin_store[i] = '0;

        dir_tab = '{
            dir_row(tdh_pkg::OP_READ,       0,      0, 0, 1, tdh_pkg::STATUS_DONE,         0, 0),
            dir_row(tdh_pkg::OP_READ,     255,     31, 3, 1, tdh_pkg::STATUS_DONE,         0, 0),
            dir_row(tdh_pkg::OP_TALLY, -32768,      0, 0, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_TALLY,  32767,      5, 1, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_TALLY,    256,      0, 2, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_TALLY,      0,     32, 1, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_TALLY,      3,     -1, 0, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_TALLY,      0, -32768, 5, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_TALLY,     10,  32767, 6, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_READ,      -1,      0, 0, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_READ,       0,      0, 4, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_TALLY,      0,      0, 0, 1, tdh_pkg::STATUS_DONE,         1, 0),
            dir_row(tdh_pkg::OP_TALLY,      0,      0, 0, 1, tdh_pkg::STATUS_DONE,         2, 0),
            dir_row(tdh_pkg::OP_TALLY,    255,     31, 3, 1, tdh_pkg::STATUS_DONE,         1, 0),
            dir_row(tdh_pkg::OP_TALLY,      0,      0, 4, 1, tdh_pkg::STATUS_MULTI_HIT,    0, 1),
            dir_row(tdh_pkg::OP_TALLY,    255,     31, 7, 1, tdh_pkg::STATUS_MULTI_HIT,    0, 2),
            dir_row(tdh_pkg::OP_TALLY,    256,     31, 7, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 2),
            dir_row(tdh_pkg::OP_READ,       0,      0, 0, 1, tdh_pkg::STATUS_DONE,         2, 2),
            dir_row(tdh_pkg::OP_READ,     255,     31, 3, 1, tdh_pkg::STATUS_DONE,         1, 2),
            dir_row(tdh_pkg::OP_READ,     255,     31, 7, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 2),
            dir_row(tdh_pkg::OP_TALLY,    100,     20, 1, 0, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_TALLY,    100,     20, 2, 0, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_READ,     100,     20, 1, 0, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_TALLY,    100,     20, 1, 0, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 0),
            dir_row(tdh_pkg::OP_READ,  -32768, -32768, 7, 1, tdh_pkg::STATUS_OUT_OF_RANGE, 0, 2)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            offer(dir_tab[i]);

        row.typed = 1'b0;
        repeat (RANDOM_ITEMS) begin
            row.item = random_event();
            offer(row);
        end
        s_valid <= 1'b0;

        // let the last transfer reach the predictor, then drain
        @(posedge aclk);
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d transfers in (%0d directed, %0d random over hot, spread and stray bins)",
                 in_taken, DIR_ROWS, RANDOM_ITEMS);
        $display("%0d results checked, %0d multi-hit events, %0d faults",
                 results_seen, multi_hits, errors);
        if (errors == 0)
            $display("two_d_histogram_tally_unit: match");
        else
            $display("two_d_histogram_tally_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

>>> two_d_histogram_tally_unit.f
rtl/core/tdh_pkg.sv
rtl/core/tdh_bin_ram.sv
rtl/core/two_d_histogram_tally_unit.sv
verif/tb.sv
